// ===== hw/rtl/csc_pkg.sv =====
package csc_pkg;

    localparam logic [7:0] PAD_CHAR  = 8'h5F;
    localparam int         NUM_COLS  = 4;
    localparam logic [1:0] COL_LAST  = 2'd3;

    // register index decoded from paddr[2]
    localparam logic REG_SHIFT_KEY = 1'b0;
    localparam logic REG_DECRYPT   = 1'b1;

    localparam logic [7:0] SHIFT_KEY_RESET = 8'd1;

    typedef struct packed {
        logic [7:0] shift_key;
        logic       decrypt_mode;
    } cfg_t;

endpackage

// ===== hw/rtl/csc_ram.sv =====
module csc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/csc_ctrl.sv =====
module csc_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  csc_pkg::cfg_t            cfg,
    // input transaction
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data,
    input  logic                     s_last,
    // buffer memory
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [7:0]               ram_wdata,
    output logic                     ram_re,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [7:0]               ram_rdata,
    // result transaction
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_data,
    output logic                     m_last,
    output logic                     m_trunc
);
    import csc_pkg::*;

    localparam int AW       = $clog2(DEPTH);
    localparam int LW       = $clog2(DEPTH + 1);
    localparam int MAX_ROWS = (DEPTH + 3) / 4;
    localparam int RW       = $clog2(MAX_ROWS + 1);
    localparam int KW       = $clog2(MAX_ROWS * 4);
    localparam int NW       = (RW > 2) ? RW : 2;
    localparam int CW       = (KW > LW) ? KW : LW;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [RW-1:0]   rows_reg, rows_next;
    logic [NW-1:0]   in_cnt_reg, in_cnt_next;
    logic [NW-1:0]   out_cnt_reg, out_cnt_next;
    logic [KW-1:0]   k_reg, k_next;
    logic            pad_reg, pad_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_byte_reg, pend_byte_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;
    logic            m_trunc_reg, m_trunc_next;

    logic            full;
    logic [LW-1:0]   len_new;
    logic [LW:0]     rows_sum;
    logic            out_free;
    logic            enc;
    logic [NW-1:0]   in_last, out_last;
    logic [KW-1:0]   k_step;
    logic [7:0]      cell_byte;
    logic            emit;
    logic            can_go;

    assign full     = (len_reg == LW'(DEPTH));
    assign len_new  = full ? len_reg : len_reg + 1'b1;
    assign rows_sum = (LW + 1)'(len_new) + (LW + 1)'(3);
    assign out_free = !m_valid_reg || m_ready;
    assign enc      = !cfg.decrypt_mode;

    // encrypt walks columns outer, rows inner; decrypt the other way round
    assign in_last  = enc ? NW'(rows_reg) - 1'b1 : NW'(COL_LAST);
    assign out_last = enc ? NW'(COL_LAST) : NW'(rows_reg) - 1'b1;
    assign k_step   = enc ? KW'(NUM_COLS) : KW'(rows_reg);

    always_comb begin
        if (enc) begin
            cell_byte = (pad_reg ? PAD_CHAR : ram_rdata) + cfg.shift_key;
            emit      = 1'b1;
        end else begin
            cell_byte = pad_reg ? PAD_CHAR : ram_rdata - cfg.shift_key;
            emit      = (cell_byte != PAD_CHAR);
        end
    end

    assign can_go = !emit || !pend_valid_reg || out_free;

    assign s_ready   = (state_reg == ST_LOAD);
    assign ram_we    = s_valid && s_ready && !full;
    assign ram_waddr = AW'(len_reg);
    assign ram_wdata = s_data;
    assign ram_re    = (state_reg == ST_READ);
    assign ram_raddr = AW'(k_reg);

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        rows_next       = rows_reg;
        in_cnt_next     = in_cnt_reg;
        out_cnt_next    = out_cnt_reg;
        k_next          = k_reg;
        pad_next        = pad_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_trunc_next    = m_trunc_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    len_next = len_new;
                    if (full) begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        rows_next       = RW'(rows_sum >> 2);
                        in_cnt_next     = '0;
                        out_cnt_next    = '0;
                        k_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_READ: begin
                pad_next   = !(CW'(k_reg) < CW'(len_reg));
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (can_go) begin
                    if (emit) begin
                        // hold one result back so the final one can carry tlast
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_byte_reg;
                            m_last_next  = 1'b0;
                            m_trunc_next = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_byte_next  = cell_byte;
                    end
                    if (in_cnt_reg == in_last) begin
                        if (out_cnt_reg == out_last) begin
                            state_next = ST_FLUSH;
                        end else begin
                            out_cnt_next = out_cnt_reg + 1'b1;
                            in_cnt_next  = '0;
                            k_next       = KW'(out_cnt_reg) + 1'b1;
                            state_next   = ST_READ;
                        end
                    end else begin
                        in_cnt_next = in_cnt_reg + 1'b1;
                        k_next      = k_reg + k_step;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = pend_byte_reg;
                        m_last_next  = 1'b1;
                        m_trunc_next = ovf_reg;
                    end
                    pend_valid_next = 1'b0;
                    len_next        = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        rows_reg      <= rows_next;
        in_cnt_reg    <= in_cnt_next;
        out_cnt_reg   <= out_cnt_next;
        k_reg         <= k_next;
        pad_reg       <= pad_next;
        pend_byte_reg <= pend_byte_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
        m_trunc_reg   <= m_trunc_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;
    assign m_trunc = m_trunc_reg;

endmodule

// ===== hw/rtl/columnar_shift_cipher.sv =====
// Input: one byte per cycle while loading; the byte marked last starts the readout.
// Readout: per matrix cell a buffer read, then an evaluate step; 4*ceil(L/4) cells,
// followed by a flush step that releases the held result.
// One result is held back so tlast can mark the final one; stalls on m_tready pause it.
// Reset clears control state, sets config defaults; the buffer memory is not cleared.
module columnar_shift_cipher #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // out_last
    output logic        m_tuser    // [0] truncated
);
    import csc_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    cfg_t            cfg_reg, cfg_next;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_SHIFT_KEY: cfg_next.shift_key    = pwdata[7:0];
                REG_DECRYPT:   cfg_next.decrypt_mode = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SHIFT_KEY: prdata = {24'd0, cfg_reg.shift_key};
            REG_DECRYPT:   prdata = {31'd0, cfg_reg.decrypt_mode};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shift_key    <= SHIFT_KEY_RESET;
            cfg_reg.decrypt_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    csc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    csc_ctrl #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata),
        .s_last    (s_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata),
        .m_last    (m_tlast),
        .m_trunc   (m_tuser)
    );

endmodule
